// ===== src/mpls_label_stack_decap_assert.svh =====
// Assertion macros used by the checker of the label stack decap block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MPLS_LABEL_STACK_DECAP_ASSERT_SVH
`define MPLS_LABEL_STACK_DECAP_ASSERT_SVH

// Same-cycle implication
`define MLSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlsd port check failed");

// Next-cycle implication
`define MLSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlsd port check failed");

`endif

// ===== src/mlsd_pkg.sv =====
package mlsd_pkg;

    localparam int TABLE_ENTRIES = 64;

    // Request kinds
    localparam logic ACT_PROG = 1'b0;
    localparam logic ACT_WORD = 1'b1;

    localparam logic [3:0] POP_MAX = 4'd15;

    typedef enum logic [1:0] {
        ST_FWD = 2'd0,
        ST_TTL = 2'd1,
        ST_BAD = 2'd2
    } status_t;

    // One decap table entry
    typedef struct packed {
        logic        valid;
        logic [15:0] fib;
        logic [19:0] label;
        logic        bottom;
        logic [7:0]  nxt;
        logic [15:0] tx_fib;
    } entry_t;

    // Lookup token that walks down the cell chain
    typedef struct packed {
        logic        vld;
        logic [15:0] fib;
        logic [19:0] label;
        logic        bottom;
        logic        found;
        logic [7:0]  nxt;
        logic [15:0] tx_fib;
    } token_t;

endpackage

// ===== src/mlsd_cell.sv =====
module mlsd_cell
    import mlsd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_entry,
    input  token_t tok_in,
    output token_t tok_out
);

    entry_t entry_reg;
    logic   valid_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   match;

    // Hold the entry payload; written only by a program request
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_entry;
        end
    end

    // Track entry validity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= wr_entry.valid;
        end
    end

    // Compare the key; an earlier cell's hit takes priority
    assign match = valid_reg && (entry_reg.fib == tok_in.fib)
                   && (entry_reg.label == tok_in.label)
                   && (entry_reg.bottom == tok_in.bottom);

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.found && match)
        begin
            tok_next.found  = 1'b1;
            tok_next.nxt    = entry_reg.nxt;
            tok_next.tx_fib = entry_reg.tx_fib;
        end
    end

    // Advance the token to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/mpls_label_stack_decap.sv =====
// MPLS label stack pop and decap lookup. Requests enter on start while busy is
// low; results leave on done for exactly one cycle and cannot be stalled, so
// the receiver must take every done pulse. A program request writes one table
// slot and leaves busy low. A label word that is dropped on a zero TTL, or
// skipped while discarding, is also taken without raising busy, with done (if
// any) on the following cycle. A label word that needs a lookup walks its key
// down a chain of TABLE_ENTRIES cells, one cell per cycle; busy stays high
// until the key leaves the last cell, done (if any) comes with busy falling,
// and the next request is taken once busy is low again. The lowest slot wins
// when several entries match.
module mpls_label_stack_decap
    import mlsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] label_word,
    input  logic        packet_start,
    input  logic [15:0] rx_fib,
    input  logic [5:0]  entry_slot,
    input  logic        entry_valid,
    input  logic [15:0] entry_fib,
    input  logic [19:0] entry_label,
    input  logic        entry_bottom,
    input  logic [7:0]  entry_next,
    input  logic [15:0] entry_tx_fib,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  next_hop,
    output logic [15:0] tx_fib,
    output logic [3:0]  labels_popped
);

    logic        use_rx_fib_reg;
    logic        busy_reg, busy_next;
    logic        discarding_reg, discarding_next;
    logic [15:0] pend_tx_reg, pend_tx_next;
    logic [3:0]  pop_cnt_reg, pop_cnt_next;
    logic        done_reg, done_next;
    status_t     status_reg, status_next;
    logic [7:0]  next_hop_reg, next_hop_next;
    logic [15:0] tx_fib_reg, tx_fib_next;
    logic [3:0]  popped_reg, popped_next;

    logic        accept;
    logic        prog_req;
    logic        word_req;
    logic        w_bottom;
    logic        skip;
    logic        ttl_drop;
    logic        launch;
    logic [15:0] eff_tx;
    logic [3:0]  eff_cnt;
    logic [3:0]  sat_cnt;
    entry_t      wr_entry;
    token_t      chain_tok [TABLE_ENTRIES+1];
    token_t      last_tok;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_rx_fib_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            use_rx_fib_reg <= cfg_wdata;
        end
    end

    // Decode the request
    assign accept   = start && !busy_reg;
    assign prog_req = accept && (action == ACT_PROG);
    assign word_req = accept && (action == ACT_WORD);
    assign w_bottom = label_word[8];
    assign skip     = !packet_start && discarding_reg;
    assign ttl_drop = (label_word[7:0] == 8'd0);
    assign launch   = word_req && !skip && !ttl_drop;
    assign eff_tx   = packet_start ? 16'd0 : pend_tx_reg;
    assign eff_cnt  = packet_start ? 4'd0 : pop_cnt_reg;

    // Build the table write and the lookup token
    assign wr_entry = '{valid: entry_valid, fib: entry_fib, label: entry_label,
                        bottom: entry_bottom, nxt: entry_next, tx_fib: entry_tx_fib};

    always_comb
    begin
        chain_tok[0]        = '0;
        chain_tok[0].vld    = launch;
        chain_tok[0].fib    = use_rx_fib_reg ? rx_fib : 16'd0;
        chain_tok[0].label  = label_word[31:12];
        chain_tok[0].bottom = w_bottom;
    end

    // Chain of match cells, lowest slot first
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        logic wr_en;
        assign wr_en = prog_req && (32'(entry_slot) == i);

        mlsd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (wr_en),
            .wr_entry (wr_entry),
            .tok_in   (chain_tok[i]),
            .tok_out  (chain_tok[i+1])
        );
    end

    assign last_tok = chain_tok[TABLE_ENTRIES];
    assign sat_cnt  = (pop_cnt_reg == POP_MAX) ? POP_MAX : pop_cnt_reg + 4'd1;

    // Packet state and result
    always_comb
    begin
        busy_next       = busy_reg;
        discarding_next = discarding_reg;
        pend_tx_next    = pend_tx_reg;
        pop_cnt_next    = pop_cnt_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        next_hop_next   = next_hop_reg;
        tx_fib_next     = tx_fib_reg;
        popped_next     = popped_reg;

        if (word_req)
        begin
            if (skip)
            begin
                // drop the word, leave discard at bottom of stack
                if (w_bottom)
                begin
                    discarding_next = 1'b0;
                end
            end
            else if (ttl_drop)
            begin
                done_next       = 1'b1;
                status_next     = ST_TTL;
                next_hop_next   = 8'd0;
                tx_fib_next     = eff_tx;
                popped_next     = eff_cnt;
                pend_tx_next    = 16'd0;
                pop_cnt_next    = 4'd0;
                discarding_next = !w_bottom;
            end
            else
            begin
                busy_next       = 1'b1;
                discarding_next = 1'b0;
                pend_tx_next    = eff_tx;
                pop_cnt_next    = eff_cnt;
            end
        end

        if (last_tok.vld)
        begin
            busy_next = 1'b0;
            if (last_tok.found)
            begin
                if (last_tok.bottom)
                begin
                    done_next     = 1'b1;
                    status_next   = ST_FWD;
                    next_hop_next = last_tok.nxt;
                    tx_fib_next   = last_tok.tx_fib;
                    popped_next   = sat_cnt;
                    pend_tx_next  = 16'd0;
                    pop_cnt_next  = 4'd0;
                end
                else
                begin
                    pend_tx_next = last_tok.tx_fib;
                    pop_cnt_next = sat_cnt;
                end
            end
            else
            begin
                done_next       = 1'b1;
                status_next     = ST_BAD;
                next_hop_next   = 8'd0;
                tx_fib_next     = pend_tx_reg;
                popped_next     = pop_cnt_reg;
                pend_tx_next    = 16'd0;
                pop_cnt_next    = 4'd0;
                discarding_next = !last_tok.bottom;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            discarding_reg <= 1'b0;
            pend_tx_reg    <= 16'd0;
            pop_cnt_reg    <= 4'd0;
            done_reg       <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            discarding_reg <= discarding_next;
            pend_tx_reg    <= pend_tx_next;
            pop_cnt_reg    <= pop_cnt_next;
            done_reg       <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        next_hop_reg <= next_hop_next;
        tx_fib_reg   <= tx_fib_next;
        popped_reg   <= popped_next;
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign next_hop      = next_hop_reg;
    assign tx_fib        = tx_fib_reg;
    assign labels_popped = popped_reg;

endmodule

// ===== src/mlsd_checker.sv =====
`include "mpls_label_stack_decap_assert.svh"

module mlsd_checker
    import mlsd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        action,
    input logic [31:0] label_word,
    input logic        packet_start,
    input logic        done,
    input logic [1:0]  status,
    input logic [7:0]  next_hop,
    input logic [3:0]  labels_popped
);

    // a program request never stalls the block
    `MLSD_ASSERT_NEXT(a_prog_no_busy, start && !busy && (action == ACT_PROG), !busy && !done)

    // a forwarded result has popped at least one label
    `MLSD_ASSERT_SAME(a_fwd_popped, done && (status == ST_FWD), labels_popped != 4'd0)

    // a dropped result carries no next hop, and the code is known
    `MLSD_ASSERT_SAME(a_drop_hop, done && (status != ST_FWD),
                      (next_hop == 8'd0) && ((status == ST_TTL) || (status == ST_BAD)))

    // a new packet with zero TTL answers as expired at once
    `MLSD_ASSERT_NEXT(a_ttl_now, start && !busy && (action == ACT_WORD) && packet_start
                      && (label_word[7:0] == 8'd0), done && (status == ST_TTL) && !busy)

endmodule

bind mpls_label_stack_decap mlsd_checker u_mlsd_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mlsd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LOOKUP_CYCLES = TABLE_ENTRIES + 4;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 200;

    // One request as it goes onto the ports
    typedef struct {
        logic        act;
        logic [31:0] word;
        logic        ps;
        logic [15:0] rxf;
        logic [5:0]  slot;
        logic        ev;
        logic [15:0] ef;
        logic [19:0] el;
        logic        eb;
        logic [7:0]  en;
        logic [15:0] et;
    } req_t;

    // One decap verdict as it leaves the block
    typedef struct {
        status_t     st;
        logic [7:0]  nh;
        logic [15:0] tx;
        logic [3:0]  pop;
    } res_t;

    typedef struct {
        req_t r;
        int   reps;
        bit   typed;
        res_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        action = 1'b0;
    logic [31:0] label_word = '0;
    logic        packet_start = 1'b0;
    logic [15:0] rx_fib = '0;
    logic [5:0]  entry_slot = '0;
    logic        entry_valid = 1'b0;
    logic [15:0] entry_fib = '0;
    logic [19:0] entry_label = '0;
    logic        entry_bottom = 1'b0;
    logic [7:0]  entry_next = '0;
    logic [15:0] entry_tx_fib = '0;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  next_hop;
    logic [15:0] tx_fib;
    logic [3:0]  labels_popped;

    // Shadow copy of the decap table and the packet state
    entry_t      decap_shadow [TABLE_ENTRIES];
    bit          key_mode = 1'b1;
    bit          discard_on = 1'b0;
    logic [7:0]  pend_next = '0;
    logic [15:0] pend_tx = '0;
    logic [3:0]  pop_cnt = '0;
    bit          word_skipped;

    res_t        decap_verdicts [$];
    row_t        dir_rows [$];

    int          cycles = 0;
    int          errors = 0;
    int          checked = 0;
    int          accepted = 0;
    int          mode_writes = 0;
    int          phase_items = 0;
    bit          no_gaps = 1'b0;

    mpls_label_stack_decap uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .label_word    (label_word),
        .packet_start  (packet_start),
        .rx_fib        (rx_fib),
        .entry_slot    (entry_slot),
        .entry_valid   (entry_valid),
        .entry_fib     (entry_fib),
        .entry_label   (entry_label),
        .entry_bottom  (entry_bottom),
        .entry_next    (entry_next),
        .entry_tx_fib  (entry_tx_fib),
        .done          (done),
        .status        (status),
        .next_hop      (next_hop),
        .tx_fib        (tx_fib),
        .labels_popped (labels_popped)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Clear the packet state after a verdict or a packet start
    function automatic void clear_packet();
        pend_next = '0;
        pend_tx   = '0;
        pop_cnt   = '0;
    endfunction

    // Apply one request to the shadow state; return 1 when it yields a verdict
    function automatic bit pop_and_lookup(input req_t r, output res_t o);
        logic [19:0] lbl;
        logic        bt;
        logic [7:0]  ttl;
        logic [15:0] fkey;
        int          hit;
        word_skipped = 1'b0;
        o = '{ST_FWD, 8'd0, 16'd0, 4'd0};
        if (r.act == ACT_PROG)
        begin
            if (r.slot < TABLE_ENTRIES)
                decap_shadow[r.slot] = '{r.ev, r.ef, r.el, r.eb, r.en, r.et};
            return 1'b0;
        end
        lbl = r.word[31:12];
        bt  = r.word[8];
        ttl = r.word[7:0];
        if (r.ps)
        begin
            discard_on = 1'b0;
            clear_packet();
        end
        else if (discard_on)
        begin
            if (bt)
                discard_on = 1'b0;
            word_skipped = 1'b1;
            return 1'b0;
        end
        if (ttl == 8'd0)
        begin
            o = '{ST_TTL, 8'd0, pend_tx, pop_cnt};
            clear_packet();
            discard_on = !bt;
            return 1'b1;
        end
        fkey = key_mode ? r.rxf : 16'd0;
        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (hit < 0 && decap_shadow[i].valid && decap_shadow[i].fib == fkey &&
                decap_shadow[i].label == lbl && decap_shadow[i].bottom == bt)
                hit = i;
        if (hit < 0)
        begin
            o = '{ST_BAD, 8'd0, pend_tx, pop_cnt};
            clear_packet();
            discard_on = !bt;
            return 1'b1;
        end
        // Pop the label and remember the match
        pend_next = decap_shadow[hit].nxt;
        pend_tx   = decap_shadow[hit].tx_fib;
        if (pop_cnt != POP_MAX)
            pop_cnt = pop_cnt + 4'd1;
        if (bt)
        begin
            o = '{ST_FWD, pend_next, pend_tx, pop_cnt};
            clear_packet();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] lw(logic [19:0] lbl, logic bt, logic [7:0] ttl);
        logic [2:0] ex;
        ex = 3'($urandom);
        return {lbl, ex, bt, ttl};
    endfunction

    function automatic req_t rq_word(logic ps, logic [31:0] w, logic [15:0] rxf);
        req_t r;
        r.act  = ACT_WORD;
        r.word = w;
        r.ps   = ps;
        r.rxf  = rxf;
        r.slot = 6'($urandom);
        r.ev   = 1'($urandom);
        r.ef   = 16'($urandom);
        r.el   = 20'($urandom);
        r.eb   = 1'($urandom);
        r.en   = 8'($urandom);
        r.et   = 16'($urandom);
        return r;
    endfunction

    function automatic req_t rq_prog(logic [5:0] slot, logic v, logic [15:0] f,
                                     logic [19:0] l, logic b, logic [7:0] n,
                                     logic [15:0] t);
        req_t r;
        r.act  = ACT_PROG;
        r.word = $urandom;
        r.ps   = 1'($urandom);
        r.rxf  = 16'($urandom);
        r.slot = slot;
        r.ev   = v;
        r.ef   = f;
        r.el   = l;
        r.eb   = b;
        r.en   = n;
        r.et   = t;
        return r;
    endfunction

    function automatic logic [15:0] pick_fib();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'h0000;
            4:          return 16'hFFFF;
            5:          return 16'h0001;
            6:          return 16'h8000;
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic logic [19:0] pick_label();
        case ($urandom_range(7))
            0:       return 20'h00000;
            1:       return 20'hFFFFF;
            2:       return 20'h00001;
            3:       return 20'h80000;
            4:       return 20'h12345;
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic add_row(input req_t r, input bit typed, input status_t st,
                           input logic [7:0] nh, input logic [15:0] tx,
                           input logic [3:0] pop);
        row_t row;
        row.r     = r;
        row.reps  = 1;
        row.typed = typed;
        row.want  = '{st, nh, tx, pop};
        dir_rows.push_back(row);
    endtask

    // Present one request, hold it until taken, then record its verdict
    task automatic issue(input req_t r, input bit typed, input res_t want);
        res_t o;
        bit   has;
        while (!no_gaps && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        action       <= r.act;
        label_word   <= r.word;
        packet_start <= r.ps;
        rx_fib       <= r.rxf;
        entry_slot   <= r.slot;
        entry_valid  <= r.ev;
        entry_fib    <= r.ef;
        entry_label  <= r.el;
        entry_bottom <= r.eb;
        entry_next   <= r.en;
        entry_tx_fib <= r.et;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        has = pop_and_lookup(r, o);
        if (has)
            decap_verdicts.push_back(typed ? want : o);
        accepted++;
        if (!word_skipped)
            phase_items++;
    endtask

    task automatic prog_random();
        logic v;
        v = $urandom_range(99) >= 15;
        issue(rq_prog(6'($urandom), v, pick_fib(), pick_label(), 1'($urandom),
                      8'($urandom), 16'($urandom)),
              1'b0, '{ST_FWD, 8'd0, 16'd0, 4'd0});
    endtask

    // Send one label stack built mostly from keys that are in the table
    task automatic send_packet();
        int          depth;
        int          s;
        int          j0;
        int          k;
        int          fl;
        logic [31:0] w;
        logic [15:0] rxf;
        logic [7:0]  ttl;
        logic        bt;
        logic        ps;
        depth = ($urandom_range(99) < 3) ? $urandom_range(18, 14) : $urandom_range(4, 1);
        for (int lvl = 0; lvl < depth; lvl++)
        begin
            bt  = (lvl == depth - 1);
            ttl = ($urandom_range(99) < 4) ? 8'd0 : 8'($urandom_range(255, 1));
            s   = -1;
            j0  = $urandom_range(TABLE_ENTRIES - 1);
            for (int j = 0; j < TABLE_ENTRIES && s < 0; j++)
            begin
                k = (j0 + j) % TABLE_ENTRIES;
                if (decap_shadow[k].valid && decap_shadow[k].bottom == bt &&
                    (key_mode || decap_shadow[k].fib == 16'd0))
                    s = k;
            end
            if (s >= 0)
            begin
                w   = lw(decap_shadow[s].label, bt, ttl);
                rxf = key_mode ? decap_shadow[s].fib : 16'($urandom);
            end
            else
            begin
                w    = $urandom;
                w[8] = bt;
                rxf  = 16'($urandom);
            end
            // Break the stack now and then with a flipped label bit
            if ($urandom_range(99) < 4)
            begin
                fl = 12 + $urandom_range(19);
                w[fl] = ~w[fl];
            end
            ps = (lvl == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            issue(rq_word(ps, w, rxf), 1'b0, '{ST_FWD, 8'd0, 16'd0, 4'd0});
        end
    endtask

    // Drop start and wait for every verdict plus one full lookup
    task automatic settle();
        start <= 1'b0;
        while (decap_verdicts.size() != 0 || busy)
            @(posedge clk);
        repeat (LOOKUP_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        key_mode  = v;
        mode_writes++;
    endtask

    // Check each verdict against the oldest one recorded
    always @(posedge clk)
    begin : chk_verdicts
        res_t w;
        if (rst_n && done)
        begin
            if (decap_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: verdict with none pending: status=%0d nh=%0h tx=%0h pop=%0d",
                             $time, status, next_hop, tx_fib, labels_popped);
            end
            else
            begin
                w = decap_verdicts.pop_front();
                checked++;
                if (status !== w.st)
                begin
                    errors++;
                    if (errors <= 40)
                        $display("%0t: status expected %0d got %0d", $time, w.st, status);
                end
                if (next_hop !== w.nh)
                begin
                    errors++;
                    if (errors <= 40)
                        $display("%0t: next_hop expected %0h got %0h", $time, w.nh, next_hop);
                end
                if (tx_fib !== w.tx)
                begin
                    errors++;
                    if (errors <= 40)
                        $display("%0t: tx_fib expected %0h got %0h", $time, w.tx, tx_fib);
                end
                if (labels_popped !== w.pop)
                begin
                    errors++;
                    if (errors <= 40)
                        $display("%0t: labels_popped expected %0d got %0d",
                                 $time, w.pop, labels_popped);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin : stim
        req_t r;
        foreach (decap_shadow[i])
            decap_shadow[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Miss, zero TTL, discarding, then the extremes of the table
        add_row(rq_word(1'b1, lw(20'h12345, 1'b1, 8'h40), 16'h0000), 1'b1, ST_BAD, 8'h00,
                16'h0000, 4'd0);
        add_row(rq_word(1'b1, lw(20'h00000, 1'b0, 8'h00), 16'h0000), 1'b1, ST_TTL, 8'h00,
                16'h0000, 4'd0);
        add_row(rq_word(1'b0, lw(20'h00000, 1'b0, 8'h05), 16'h0000), 1'b0, ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b0, lw(20'h00000, 1'b1, 8'h05), 16'h0000), 1'b0, ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b0, lw(20'h00000, 1'b1, 8'h05), 16'h0000), 1'b1, ST_BAD, 8'h00,
                16'h0000, 4'd0);
        add_row(rq_prog(6'd0, 1'b1, 16'hFFFF, 20'hFFFFF, 1'b0, 8'hFF, 16'hFFFF), 1'b0,
                ST_FWD, 0, 0, 0);
        add_row(rq_prog(6'd63, 1'b1, 16'hFFFF, 20'hFFFFF, 1'b1, 8'hA5, 16'h5A5A), 1'b0,
                ST_FWD, 0, 0, 0);
        // Same key in a lower slot must win
        add_row(rq_prog(6'd1, 1'b1, 16'hFFFF, 20'hFFFFF, 1'b1, 8'h11, 16'h2222), 1'b0,
                ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b1, lw(20'hFFFFF, 1'b0, 8'hFF), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b0, lw(20'hFFFFF, 1'b1, 8'h01), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b1, lw(20'hFFFFF, 1'b0, 8'h01), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b0, lw(20'h00000, 1'b0, 8'h01), 16'hFFFF), 1'b1, ST_BAD, 8'h00,
                16'hFFFF, 4'd1);
        // Packet start ends discarding
        add_row(rq_word(1'b1, lw(20'hFFFFF, 1'b1, 8'hFF), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        add_row(rq_prog(6'd1, 1'b0, 16'hFFFF, 20'hFFFFF, 1'b1, 8'h00, 16'h0000), 1'b0,
                ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b1, lw(20'hFFFFF, 1'b1, 8'hFF), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        // Zero TTL on the bottom word, then words that start fresh packets
        add_row(rq_word(1'b1, lw(20'hFFFFF, 1'b0, 8'h10), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b0, lw(20'hFFFFF, 1'b1, 8'h00), 16'hFFFF), 1'b1, ST_TTL, 8'h00,
                16'hFFFF, 4'd1);
        add_row(rq_word(1'b0, lw(20'hFFFFF, 1'b1, 8'h80), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b0, lw(20'hFFFFF, 1'b1, 8'h80), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        // Deep stack saturates the pop count
        add_row(rq_word(1'b1, lw(20'hFFFFF, 1'b0, 8'h33), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        add_row(rq_word(1'b0, lw(20'hFFFFF, 1'b0, 8'h33), 16'hFFFF), 1'b0, ST_FWD, 0, 0, 0);
        dir_rows[dir_rows.size() - 1].reps = 16;
        add_row(rq_word(1'b0, lw(20'hFFFFF, 1'b1, 8'h33), 16'hFFFF), 1'b1, ST_FWD, 8'hA5,
                16'h5A5A, POP_MAX);
        add_row(rq_word(1'b1, lw(20'hFFFFF, 1'b1, 8'h33), 16'hFFFE), 1'b0, ST_FWD, 0, 0, 0);

        foreach (dir_rows[i])
            for (int k = 0; k < dir_rows[i].reps; k++)
                issue(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);

        // Random phases, alternating the lookup key mode between them
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            set_mode(ph % 2 == 0);
            no_gaps = (ph == 2);
            phase_items = 0;
            for (int n = 0; n < 16; n++)
                prog_random();
            while (phase_items < PHASE_ITEMS)
            begin
                case ($urandom_range(9))
                    0: prog_random();
                    1:
                    begin
                        r = rq_word(1'($urandom_range(1)), $urandom, 16'($urandom));
                        issue(r, 1'b0, '{ST_FWD, 8'd0, 16'd0, 4'd0});
                    end
                    default: send_packet();
                endcase
            end
        end
        settle();

        $display("%0d requests taken, %0d verdicts checked, %0d key mode writes",
                 accepted, checked, mode_writes);
        $display("covered misses, zero TTL, discarding, slot priority and pop saturation");
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
